// ===== hw/rtl/phv_pkg.sv =====
// Shared types, score constants and saturating score arithmetic for the
// profile HMM Viterbi scorer. No dependencies.
`timescale 1ns / 1ps

package phv_pkg;

  localparam int SCORE_W = 32;
  localparam int SYM_W   = 5;
  localparam int NODE_W  = 11;
  localparam int KIND_W  = 3;
  localparam int ACT_W   = 3;
  localparam int RC_W    = 16;
  localparam int LEN_W   = 11;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t NEG_INF   = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam score_t POS_LIMIT = {1'b0, {(SCORE_W-1){1'b1}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_TR  = 3'd0,
    ACT_LOAD_ME  = 3'd1,
    ACT_LOAD_IE  = 3'd2,
    ACT_LOAD_SP  = 3'd3,
    ACT_RESIDUE  = 3'd4
  } action_t;

  localparam logic [KIND_W-1:0] TR_M2M = 3'd0;
  localparam logic [KIND_W-1:0] TR_M2I = 3'd1;
  localparam logic [KIND_W-1:0] TR_M2D = 3'd2;
  localparam logic [KIND_W-1:0] TR_I2M = 3'd3;
  localparam logic [KIND_W-1:0] TR_I2I = 3'd4;
  localparam logic [KIND_W-1:0] TR_D2M = 3'd5;
  localparam logic [KIND_W-1:0] TR_D2D = 3'd6;
  localparam logic [KIND_W-1:0] TR_B2M = 3'd7;

  localparam logic [KIND_W-1:0] SP_NLOOP = 3'd0;
  localparam logic [KIND_W-1:0] SP_NMOVE = 3'd1;
  localparam logic [KIND_W-1:0] SP_ELOOP = 3'd2;
  localparam logic [KIND_W-1:0] SP_EMOVE = 3'd3;
  localparam logic [KIND_W-1:0] SP_CLOOP = 3'd4;
  localparam logic [KIND_W-1:0] SP_CMOVE = 3'd5;
  localparam logic [KIND_W-1:0] SP_JLOOP = 3'd6;
  localparam logic [KIND_W-1:0] SP_JMOVE = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;   // table or special load request
    logic cap;       // capture a residue request, k := 1
    logic init_q;    // query start: N, B, C, J
    logic rd;        // read tables and rows at node k
    logic add;       // transition sums
    logic fin;       // finish node k and write the row cells
    logic clr;       // write minus infinity at node k
    logic k_inc;
    logic end_e;     // E, J, C, N update
    logic end_b;     // B update and row count
    logic out_ld;    // load the result register
  } phv_cmd_t;

  typedef struct packed {
    logic rc_zero;
    logic first_row;
    logic k_is_len;
    logic k_is_max;
    logic last;
    logic out_busy;
  } phv_sts_t;

  function automatic score_t sadd(input score_t a, input score_t b);
    logic signed [SCORE_W:0] s;
    s = $signed({a[SCORE_W-1], a}) + $signed({b[SCORE_W-1], b});
    if (a == NEG_INF || b == NEG_INF) begin
      return NEG_INF;
    end else if (s > $signed({POS_LIMIT[SCORE_W-1], POS_LIMIT})) begin
      return POS_LIMIT;
    end else if (s <= $signed({NEG_INF[SCORE_W-1], NEG_INF})) begin
      return NEG_INF;
    end
    return s[SCORE_W-1:0];
  endfunction

  function automatic score_t smax(input score_t a, input score_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/phv_ctrl.sv =====
// Sequencing state machine of the Viterbi scorer: request intake, node sweep,
// clearing pass and special-state updates. Depends on phv_pkg.
`timescale 1ns / 1ps

module phv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [2:0]        in_action,
  input  phv_pkg::phv_sts_t sts,
  output logic              in_ready,
  output phv_pkg::phv_cmd_t cmd
);
  import phv_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_RD    = 9'b000000100,
    S_ADD   = 9'b000001000,
    S_FIN   = 9'b000010000,
    S_CLR   = 9'b000100000,
    S_ENDE  = 9'b001000000,
    S_ENDB  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_RESIDUE) begin
            cmd.cap = 1'b1;
            state_nxt = sts.rc_zero ? S_START : S_RD;
          end else begin
            cmd.load_en = 1'b1;
          end
        end
      end
      S_START: begin
        cmd.init_q = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (!sts.k_is_len) begin
          cmd.k_inc = 1'b1;
          state_nxt = S_RD;
        end else if (sts.first_row && !sts.k_is_max) begin
          // The first row of a query also wipes the nodes past the profile.
          cmd.k_inc = 1'b1;
          state_nxt = S_CLR;
        end else begin
          state_nxt = S_ENDE;
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.k_is_max) begin
          state_nxt = S_ENDE;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_ENDE: begin
        cmd.end_e = 1'b1;
        state_nxt = S_ENDB;
      end
      S_ENDB: begin
        cmd.end_b = 1'b1;
        state_nxt = sts.last ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/phv_datapath.sv =====
// Score tables, DP row memories, cell arithmetic and special states of the
// Viterbi scorer. Driven by phv_ctrl commands; depends on phv_pkg.
`timescale 1ns / 1ps

module phv_datapath #(
  parameter int MAX_NODES     = 1024,
  parameter int ALPHABET_SIZE = 32,
  parameter int MAX_QUERY_LEN = 65535
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  phv_pkg::phv_cmd_t             cmd,
  output phv_pkg::phv_sts_t             sts,
  input  logic                          cfg_wr_en,
  input  logic [phv_pkg::LEN_W-1:0]     cfg_wr_data,
  input  logic [phv_pkg::ACT_W-1:0]     in_action,
  input  logic [phv_pkg::NODE_W-1:0]    in_node,
  input  logic [phv_pkg::KIND_W-1:0]    in_kind,
  input  logic [phv_pkg::SYM_W-1:0]     in_symbol,
  input  logic [phv_pkg::SCORE_W-1:0]   in_score,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [phv_pkg::SCORE_W-1:0]   out_total,
  output logic [phv_pkg::RC_W-1:0]      out_count
);
  import phv_pkg::*;

  localparam int NW      = $clog2(MAX_NODES + 1);
  localparam int DEPTH   = MAX_NODES + 1;
  localparam int EDEPTH  = DEPTH * (1 << SYM_W);
  localparam int EW      = NW + SYM_W;

  // Configuration and effective profile length.
  logic [LEN_W-1:0] plen_r;
  logic [NW-1:0]    len_eff;
  always_comb begin
    if (plen_r == '0) begin
      len_eff = NW'(1);
    end else if (32'(plen_r) > MAX_NODES) begin
      len_eff = NW'(MAX_NODES);
    end else begin
      len_eff = NW'(plen_r);
    end
  end

  // Load decode.
  logic [31:0] node_full;
  logic        node_ok, sym_in_ok;
  logic [NW-1:0] node_a;
  score_t      val;
  assign node_full = 32'(in_node);
  assign node_ok   = node_full <= MAX_NODES;
  assign sym_in_ok = 32'(in_symbol) < ALPHABET_SIZE;
  assign node_a    = node_full[NW-1:0];
  assign val       = in_score;

  logic tr_we, me_we, ie_we;
  assign tr_we = cmd.load_en && in_action == ACT_LOAD_TR && node_ok;
  assign me_we = cmd.load_en && in_action == ACT_LOAD_ME && node_ok && sym_in_ok;
  assign ie_we = cmd.load_en && in_action == ACT_LOAD_IE && node_ok && sym_in_ok;

  // Captured residue.
  logic [SYM_W-1:0] sym_r;
  logic             sym_ok_r, last_r, frow_r;
  logic [NW-1:0]    k_r;
  logic [RC_W-1:0]  rc_r;

  // Transition tables, one memory per kind.
  score_t tr_q [8];
  logic [NW-1:0] k_prev;
  assign k_prev = k_r - NW'(1);

  for (genvar g = 0; g < 8; g++) begin : g_tr
    score_t mem [0:DEPTH-1];
    score_t q_r;
    always_ff @(posedge clk) begin
      if (tr_we && in_kind == KIND_W'(g)) begin
        mem[node_a] <= val;
      end
      if (cmd.rd) begin
        // Insert transitions leave node k; the rest enter node k from k-1.
        if (KIND_W'(g) == TR_M2I || KIND_W'(g) == TR_I2I) begin
          q_r <= mem[k_r];
        end else begin
          q_r <= mem[k_prev];
        end
      end
    end
    assign tr_q[g] = q_r;
  end

  // Emission tables.
  score_t me_mem [0:EDEPTH-1];
  score_t ie_mem [0:EDEPTH-1];
  score_t me_q, ie_q;
  logic [EW-1:0] e_wa, e_ra;
  assign e_wa = {node_a, in_symbol};
  assign e_ra = {k_r, sym_r};

  always_ff @(posedge clk) begin
    if (me_we) me_mem[e_wa] <= val;
    if (ie_we) ie_mem[e_wa] <= val;
    if (cmd.rd) begin
      me_q <= me_mem[e_ra];
      ie_q <= ie_mem[e_ra];
    end
  end

  // DP rows.
  score_t m_mem [0:DEPTH-1];
  score_t i_mem [0:DEPTH-1];
  score_t d_mem [0:DEPTH-1];
  score_t om_q, oi_q, od_q;
  score_t nm, ni, nd;

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      m_mem[k_r] <= nm;
      i_mem[k_r] <= ni;
      d_mem[k_r] <= nd;
    end else if (cmd.clr) begin
      m_mem[k_r] <= NEG_INF;
      i_mem[k_r] <= NEG_INF;
      d_mem[k_r] <= NEG_INF;
    end
    if (cmd.rd) begin
      om_q <= m_mem[k_r];
      oi_q <= i_mem[k_r];
      od_q <= d_mem[k_r];
    end
  end

  // Old row values; the first row of a query sees minus infinity everywhere.
  score_t om, oi, od;
  assign om = frow_r ? NEG_INF : om_q;
  assign oi = frow_r ? NEG_INF : oi_q;
  assign od = frow_r ? NEG_INF : od_q;

  score_t sp_r [8];
  score_t pm_r, pi_r, pd_r, cm_r, cd_r;
  score_t n_r, b_r, c_r, j_r;
  score_t a_m2m_r, a_i2m_r, a_d2m_r, a_b2m_r, a_m2i_r, a_i2i_r, a_m2d_r, a_d2d_r;
  score_t em_r, ie_r;

  always_comb begin
    nm = sadd(smax(smax(a_m2m_r, a_i2m_r), smax(a_d2m_r, a_b2m_r)), em_r);
    ni = (k_r == len_eff) ? NEG_INF : sadd(smax(a_m2i_r, a_i2i_r), ie_r);
    nd = smax(a_m2d_r, a_d2d_r);
  end

  score_t e_new, j_new, n_new;
  assign e_new = smax(cm_r, cd_r);
  assign j_new = smax(sadd(j_r, sp_r[SP_JLOOP]), sadd(e_new, sp_r[SP_ELOOP]));
  assign n_new = sadd(n_r, sp_r[SP_NLOOP]);

  always_ff @(posedge clk) begin
    if (cmd.load_en && in_action == ACT_LOAD_SP) begin
      sp_r[in_kind] <= val;
    end
    if (cmd.cap) begin
      sym_r    <= in_symbol;
      sym_ok_r <= sym_in_ok;
      last_r   <= in_last;
      frow_r   <= (rc_r == '0);
      pm_r <= NEG_INF; pi_r <= NEG_INF; pd_r <= NEG_INF;
      cm_r <= NEG_INF; cd_r <= NEG_INF;
    end
    if (cmd.add) begin
      a_m2m_r <= sadd(pm_r, tr_q[TR_M2M]);
      a_i2m_r <= sadd(pi_r, tr_q[TR_I2M]);
      a_d2m_r <= sadd(pd_r, tr_q[TR_D2M]);
      a_b2m_r <= sadd(b_r, tr_q[TR_B2M]);
      a_m2i_r <= sadd(om, tr_q[TR_M2I]);
      a_i2i_r <= sadd(oi, tr_q[TR_I2I]);
      a_m2d_r <= sadd(cm_r, tr_q[TR_M2D]);
      a_d2d_r <= sadd(cd_r, tr_q[TR_D2D]);
      em_r    <= sym_ok_r ? me_q : NEG_INF;
      ie_r    <= sym_ok_r ? ie_q : NEG_INF;
    end
    if (cmd.fin) begin
      pm_r <= om; pi_r <= oi; pd_r <= od;
      cm_r <= nm; cd_r <= nd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r    <= LEN_W'(1);
      k_r       <= NW'(1);
      rc_r      <= '0;
      out_valid <= 1'b0;
      n_r <= '0; b_r <= '0;
      c_r <= NEG_INF; j_r <= NEG_INF;
    end else begin
      if (cfg_wr_en) plen_r <= cfg_wr_data;
      if (cmd.cap) begin
        k_r <= NW'(1);
      end else if (cmd.k_inc) begin
        k_r <= k_r + NW'(1);
      end
      if (cmd.init_q) begin
        n_r <= '0;
        b_r <= sp_r[SP_NMOVE];
        c_r <= NEG_INF; j_r <= NEG_INF;
      end
      if (cmd.end_e) begin
        j_r <= j_new;
        c_r <= smax(sadd(c_r, sp_r[SP_CLOOP]), sadd(e_new, sp_r[SP_EMOVE]));
        n_r <= n_new;
      end
      if (cmd.end_b) begin
        b_r <= smax(sadd(n_r, sp_r[SP_NMOVE]), sadd(j_r, sp_r[SP_JMOVE]));
        if (rc_r < RC_W'(MAX_QUERY_LEN)) rc_r <= rc_r + RC_W'(1);
      end
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
        rc_r      <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_total <= sadd(c_r, sp_r[SP_CMOVE]);
      out_count <= rc_r;
    end
  end

  always_comb begin
    sts.rc_zero   = (rc_r == '0);
    sts.first_row = frow_r;
    sts.k_is_len  = (k_r == len_eff);
    sts.k_is_max  = (k_r == NW'(MAX_NODES));
    sts.last      = last_r;
    sts.out_busy  = out_valid && !out_ready;
  end

endmodule

// ===== hw/rtl/profile_hmm_viterbi_score.sv =====
// Top level of the glocal profile HMM Viterbi scorer: stream ports,
// controller and datapath. Depends on phv_pkg, phv_ctrl, phv_datapath.
//
// Channel  Dir  Handshake           Payload
// in       in   in_tvalid/tready    tdata node,symbol,score; tuser action,kind;
//                                   tlast last_residue
// out      out  out_tvalid/tready   tdata total_score,residue_count
// cfg      in   cfg_wr_en           cfg_wr_data profile_length
//
// A load request leaves intake open. A residue runs a read, add and write
// pass over the single-port rows for each node up to the profile length L,
// then the E and B end updates; one that yields a result then loads the
// output register once an earlier result has gone. The first residue of
// each query adds a start state and a clearing pass over the row memories
// past the profile. Reset sets control state, residue count and special
// scores to start values and the profile length to 1, not tables or rows.
// A waiting result holds in the output register while loads are accepted.
`timescale 1ns / 1ps

module profile_hmm_viterbi_score #(
  parameter int MAX_NODES     = 1024,
  parameter int ALPHABET_SIZE = 32,
  parameter int MAX_QUERY_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // node[10:0], symbol[15:11], score_value[47:16]
  input  logic [5:0]  in_tuser,   // action[2:0], kind[5:3]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // total_score[31:0], residue_count[47:32]
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);
  import phv_pkg::*;

  phv_cmd_t cmd;
  phv_sts_t sts;
  logic     in_fire;
  logic [SCORE_W-1:0] total;
  logic [RC_W-1:0]    count;

  assign in_fire = in_tvalid && in_tready;

  phv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_action (in_tuser[2:0]),
    .sts       (sts),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  phv_datapath #(
    .MAX_NODES     (MAX_NODES),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_QUERY_LEN (MAX_QUERY_LEN)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_action   (in_tuser[2:0]),
    .in_node     (in_tdata[10:0]),
    .in_kind     (in_tuser[5:3]),
    .in_symbol   (in_tdata[15:11]),
    .in_score    (in_tdata[47:16]),
    .in_last     (in_tlast),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_total   (total),
    .out_count   (count)
  );

  assign out_tdata = {count, total};

endmodule

// ===== hw/rtl/phv_checker.sv =====
// Port-level assertions for the Viterbi scorer and their bind to the top
// level. Depends on phv_pkg and profile_hmm_viterbi_score.
`timescale 1ns / 1ps

module phv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [5:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  import phv_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Every result counts at least the residue that produced it.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] != 16'd0)
    else $error("result with zero residue count");

  // A residue request starts a row sweep, so intake closes right after it.
  a_residue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[2:0] == ACT_RESIDUE |=> !in_tready)
    else $error("intake open during a row sweep");

  // Load requests leave intake open.
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[2:0] != ACT_RESIDUE |=> in_tready)
    else $error("intake closed after a load request");

endmodule

bind profile_hmm_viterbi_score phv_checker u_phv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb.sv =====
// Self-checking testbench for profile_hmm_viterbi_score: drives table loads and residue
// requests, predicts each query score with its own Viterbi model. Depends on phv_pkg.
`timescale 1ns / 1ps

module tb;
  import phv_pkg::*;

  localparam int NODES  = 1024;
  localparam int ALPHA  = 32;
  localparam int MAXL   = 8;   // longest profile swept by the residues
  localparam int SYMS   = 4;   // random residues use symbols 0 to SYMS-1
  localparam int SETTLE = 4 * NODES + 64;

  class viterbi_scoreboard;
    score_t tr_tab[0:NODES][0:7];
    score_t mem_tab[0:NODES][0:ALPHA-1];
    score_t ins_tab[0:NODES][0:ALPHA-1];
    score_t spec[0:7];
    score_t m_row[0:NODES];
    score_t i_row[0:NODES];
    score_t d_row[0:NODES];
    score_t n_sc, b_sc, e_sc, c_sc, j_sc;
    int unsigned rows, plen;
    logic [47:0] expected_scores[$];
    int errors, checked, residues;

    function new();
      plen = 1;
      rows = 0;
      b_sc = '0;
    endfunction

    function score_t add_sat(score_t a, score_t b);
      longint s;
      if (a == NEG_INF || b == NEG_INF) return NEG_INF;
      s = longint'(a) + longint'(b);
      if (s > 64'sd2147483647) return POS_LIMIT;
      if (s <= -64'sd2147483648) return NEG_INF;
      return score_t'(s);
    endfunction

    function score_t best(score_t a, score_t b);
      return (a > b) ? a : b;
    endfunction

    function void set_length(int unsigned v);
      plen = v;
    endfunction

    function int pending();
      return expected_scores.size();
    endfunction

    function void note_request(logic [2:0] act, logic [10:0] node, logic [2:0] kind,
                               logic [4:0] sym, score_t v, bit last);
      int unsigned len;
      score_t pm, pi, pd, cm, cd, om, oi, od, bb, nm, ni, nd, tmp;
      case (act)
        ACT_LOAD_TR: if (node <= NODES) tr_tab[node][kind] = v;
        ACT_LOAD_ME: if (node <= NODES) mem_tab[node][sym] = v;
        ACT_LOAD_IE: if (node <= NODES) ins_tab[node][sym] = v;
        ACT_LOAD_SP: spec[kind] = v;
        ACT_RESIDUE: begin
          residues++;
          if (rows == 0) begin
            for (int k = 0; k <= NODES; k++) begin
              m_row[k] = NEG_INF;
              i_row[k] = NEG_INF;
              d_row[k] = NEG_INF;
            end
            n_sc = '0;
            b_sc = spec[SP_NMOVE];
            e_sc = NEG_INF;
            c_sc = NEG_INF;
            j_sc = NEG_INF;
          end
          len = (plen < 1) ? 1 : (plen > NODES) ? NODES : plen;
          pm = NEG_INF; pi = NEG_INF; pd = NEG_INF; cm = NEG_INF; cd = NEG_INF;
          bb = b_sc;
          for (int unsigned k = 1; k <= len; k++) begin
            om = m_row[k]; oi = i_row[k]; od = d_row[k];
            tmp = best(best(add_sat(pm, tr_tab[k-1][TR_M2M]), add_sat(pi, tr_tab[k-1][TR_I2M])),
                       best(add_sat(pd, tr_tab[k-1][TR_D2M]), add_sat(bb, tr_tab[k-1][TR_B2M])));
            nm = add_sat(tmp, mem_tab[k][sym]);
            if (k < len) begin
              tmp = best(add_sat(om, tr_tab[k][TR_M2I]), add_sat(oi, tr_tab[k][TR_I2I]));
              ni = add_sat(tmp, ins_tab[k][sym]);
            end else begin
              ni = NEG_INF;
            end
            nd = best(add_sat(cm, tr_tab[k-1][TR_M2D]), add_sat(cd, tr_tab[k-1][TR_D2D]));
            m_row[k] = nm; i_row[k] = ni; d_row[k] = nd;
            pm = om; pi = oi; pd = od;
            cm = nm; cd = nd;
          end
          e_sc = best(cm, cd);
          j_sc = best(add_sat(j_sc, spec[SP_JLOOP]), add_sat(e_sc, spec[SP_ELOOP]));
          c_sc = best(add_sat(c_sc, spec[SP_CLOOP]), add_sat(e_sc, spec[SP_EMOVE]));
          n_sc = add_sat(n_sc, spec[SP_NLOOP]);
          b_sc = best(add_sat(n_sc, spec[SP_NMOVE]), add_sat(j_sc, spec[SP_JMOVE]));
          if (rows < 65535) rows++;
          if (last) begin
            expected_scores.push_back({rows[15:0], add_sat(c_sc, spec[SP_CMOVE])});
            rows = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [47:0] got);
      logic [47:0] exp_word;
      bit bad;
      if (expected_scores.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_word = expected_scores.pop_front();
      checked++;
      bad = 0;
      if (got[31:0] !== exp_word[31:0]) bad = 1;
      if (got[47:32] !== exp_word[47:32]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: total_score exp %0d got %0d, residue_count exp %0d got %0d",
                   $signed(exp_word[31:0]), $signed(got[31:0]), exp_word[47:32], got[47:32]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [5:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  viterbi_scoreboard sb = new();
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_left = 0;
  int unsigned cur_len = 1;

  profile_hmm_viterbi_score u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic score_t rnd_score();
    int r;
    r = $urandom_range(99);
    if (r < 8) return NEG_INF;
    if (r < 12) return POS_LIMIT;
    if (r < 18) return score_t'($urandom);
    if (r < 25) return score_t'($urandom_range(500));
    return -score_t'($urandom_range(3000));
  endfunction

  task automatic send(input logic [2:0] act, input logic [10:0] node, input logic [2:0] kind,
                      input logic [4:0] sym, input score_t v, input bit last);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, sym, node};
    in_tuser  <= {kind, act};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(act, node, kind, sym, v, last);
  endtask

  // Waits until every expected result has come, then lets a residue without
  // a result finish its sweep.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_length(input int unsigned v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[10:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_length(v);
    cur_len = v;
  endtask

  task automatic random_items(input int n);
    int r;
    logic [10:0] nd;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      nd = 11'($urandom_range(cur_len + 1));
      if ($urandom_range(9) == 0) nd = 11'($urandom_range(2047, NODES + 1));
      if (r < 60)
        send(ACT_RESIDUE, 11'($urandom), 3'($urandom), 5'($urandom_range(SYMS - 1)),
             score_t'($urandom), $urandom_range(3) == 0);
      else if (r < 95)
        send(3'($urandom_range(ACT_LOAD_TR, ACT_LOAD_SP)), nd, 3'($urandom), 5'($urandom),
             rnd_score(), 1'($urandom));
      else
        send(ACT_RESIDUE + 3'($urandom_range(1, 3)), 11'($urandom), 3'($urandom),
             5'($urandom), score_t'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int unsigned lens[9] = '{0, 3, 8, 7, 1, 6, 2, 5, 4};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_length(1);

    // Every table entry that a sweep over symbols 0 to SYMS-1 can touch is written before any residue.
    for (int n = 0; n <= MAXL; n++) begin
      for (int k = 0; k < 8; k++) send(ACT_LOAD_TR, 11'(n), 3'(k), 5'd0, rnd_score(), 1'b0);
      for (int s = 0; s < SYMS; s++) begin
        send(ACT_LOAD_ME, 11'(n), 3'd0, 5'(s), -score_t'($urandom_range(2000)), 1'b0);
        send(ACT_LOAD_IE, 11'(n), 3'd0, 5'(s), -score_t'($urandom_range(2000)), 1'b0);
      end
    end
    for (int k = 0; k < 8; k++)
      send(ACT_LOAD_SP, 11'd0, 3'(k), 5'd0, -score_t'($urandom_range(50)), 1'b0);

    // Directed: saturation high, impossible paths, ignored loads, spare actions.
    send(ACT_RESIDUE, 11'd0, 3'd0, 5'd3, '0, 1'b1);
    send(ACT_LOAD_TR, 11'd0, TR_B2M, 5'd0, POS_LIMIT, 1'b0);
    send(ACT_LOAD_ME, 11'd1, 3'd0, 5'd0, POS_LIMIT, 1'b0);
    send(ACT_LOAD_SP, 11'd0, SP_EMOVE, 5'd0, POS_LIMIT, 1'b0);
    send(ACT_RESIDUE, 11'd0, 3'd0, 5'd0, '0, 1'b1);
    send(ACT_LOAD_ME, 11'd1, 3'd0, 5'd31, NEG_INF, 1'b0);
    send(ACT_RESIDUE, 11'd0, 3'd0, 5'd31, '0, 1'b1);
    send(ACT_LOAD_TR, 11'd2047, TR_B2M, 5'd0, NEG_INF, 1'b0);
    send(ACT_LOAD_ME, 11'd1025, 3'd0, 5'd5, NEG_INF, 1'b0);
    send(ACT_LOAD_IE, 11'd1600, 3'd0, 5'd31, NEG_INF, 1'b0);
    send(ACT_RESIDUE + 3'd1, 11'd2047, 3'd7, 5'd31, NEG_INF, 1'b1);
    send(ACT_RESIDUE + 3'd2, 11'd0, 3'd0, 5'd0, POS_LIMIT, 1'b0);
    send(ACT_RESIDUE + 3'd3, 11'd1024, 3'd5, 5'd16, '0, 1'b1);
    send(ACT_LOAD_SP, 11'd0, SP_EMOVE, 5'd0, -score_t'(10), 1'b0);
    send(ACT_LOAD_SP, 11'd0, SP_CMOVE, 5'd0, -score_t'(2147483647), 1'b0);
    send(ACT_RESIDUE, 11'd0, 3'd0, 5'd2, '0, 1'b0);
    send(ACT_RESIDUE, 11'd0, 3'd0, 5'd1, '0, 1'b0);
    send(ACT_RESIDUE, 11'd0, 3'd0, 5'd0, '0, 1'b1);
    send(ACT_LOAD_SP, 11'd0, SP_CMOVE, 5'd0, -score_t'(5), 1'b0);
    send(ACT_LOAD_SP, 11'd0, SP_JMOVE, 5'd0, NEG_INF, 1'b0);
    send(ACT_RESIDUE, 11'd0, 3'd0, 5'd1, '0, 1'b0);
    send(ACT_RESIDUE, 11'd0, 3'd0, 5'd1, '0, 1'b1);
    drain();

    foreach (lens[p]) begin
      snd_idle = (p < 3) ? 33 : (p < 6) ? 83 : 0;
      rcv_idle = (p < 3) ? 83 : (p < 6) ? 33 : 0;
      set_length(lens[p]);
      if (p == 1) hold_left = 6000;
      random_items(40);
      if (p == 4) drain();
      random_items(6);
      drain();
    end

    $display("covered %0d residue requests over profile lengths 0 to %0d", sb.residues, MAXL);
    $display("%0d query scores compared, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
